/* design/wlsp_pkg.sv */
// Shared types, constants and codes of the weight-limited shortest path block.
package wlsp_pkg;

    localparam int FUNC_W        = 2;
    localparam int NODE_IN_W     = 10;
    localparam int LEN_W         = 16;
    localparam int WT_W          = 16;
    localparam int DIST_W        = 26;
    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_MAX_EDGES = 4096;

    localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD  = 2'd0,
        FUNC_RUN  = 2'd1,
        FUNC_READ = 2'd2
    } t_func;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_ADD_CHK, S_LINK_A, S_HEAD_B, S_LINK_B,
        S_RUN_CLR, S_START, S_SCAN, S_SCAN_END, S_PICK, S_LINK_GET,
        S_EDGE_CHK, S_EDGE_GOT, S_RELAX, S_READ_RD, S_READ_FIN, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_CLEAR_ALL, OP_CLEAR_RUN, OP_ADD_CHK,
        OP_LINK_A, OP_HEAD_RD_B, OP_LINK_B, OP_START, OP_SCAN_INIT,
        OP_SCAN, OP_SCAN_END, OP_SETTLE, OP_LINK_GET, OP_EDGE_RD,
        OP_EDGE_GOT, OP_RELAX, OP_READ_RD, OP_READ_FIN, OP_PUSH
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic ctr_last;
        logic full;
        logic a_ok;
        logic b_ok;
        logic found;
        logic link_ok;
        logic out_busy;
    } t_sts;

endpackage

/* design/wlsp_ctrl.sv */
// Controller state machine that sequences the datapath of the shortest path block.
module wlsp_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [wlsp_pkg::FUNC_W-1:0] i_func,
    input  wlsp_pkg::t_sts              i_sts,
    output wlsp_pkg::t_cmd              o_cmd,
    output logic                        o_stall
);
    import wlsp_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        case (r_state)
            S_INIT: begin
                o_cmd.op = OP_CLEAR_ALL;
                if (i_sts.ctr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    case (t_func'(i_func))
                        FUNC_ADD:  n_state = S_ADD_CHK;
                        FUNC_RUN:  n_state = S_RUN_CLR;
                        FUNC_READ: n_state = S_READ_RD;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_ADD_CHK: begin
                o_cmd.op = OP_ADD_CHK;
                if (i_sts.full || !(i_sts.a_ok && i_sts.b_ok)) n_state = S_DONE;
                else n_state = S_LINK_A;
            end
            S_LINK_A: begin
                o_cmd.op = OP_LINK_A;
                n_state  = S_HEAD_B;
            end
            S_HEAD_B: begin
                o_cmd.op = OP_HEAD_RD_B;
                n_state  = S_LINK_B;
            end
            S_LINK_B: begin
                o_cmd.op = OP_LINK_B;
                n_state  = S_DONE;
            end
            S_RUN_CLR: begin
                o_cmd.op = OP_CLEAR_RUN;
                if (i_sts.ctr_last) n_state = S_START;
            end
            S_START: begin
                o_cmd.op = OP_START;
                n_state  = i_sts.a_ok ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                o_cmd.op = OP_SCAN;
                if (i_sts.ctr_last) n_state = S_SCAN_END;
            end
            S_SCAN_END: begin
                o_cmd.op = OP_SCAN_END;
                n_state  = S_PICK;
            end
            S_PICK: begin
                if (i_sts.found) begin
                    o_cmd.op = OP_SETTLE;
                    n_state  = S_LINK_GET;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_LINK_GET: begin
                o_cmd.op = OP_LINK_GET;
                n_state  = S_EDGE_CHK;
            end
            S_EDGE_CHK: begin
                if (i_sts.link_ok) begin
                    o_cmd.op = OP_EDGE_RD;
                    n_state  = S_EDGE_GOT;
                end else begin
                    o_cmd.op = OP_SCAN_INIT;
                    n_state  = S_SCAN;
                end
            end
            S_EDGE_GOT: begin
                o_cmd.op = OP_EDGE_GOT;
                n_state  = S_RELAX;
            end
            S_RELAX: begin
                o_cmd.op = OP_RELAX;
                n_state  = S_EDGE_CHK;
            end
            S_READ_RD: begin
                o_cmd.op = OP_READ_RD;
                n_state  = S_READ_FIN;
            end
            S_READ_FIN: begin
                o_cmd.op = OP_READ_FIN;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.op = OP_PUSH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* design/wlsp_datapath.sv */
// Datapath: edge store, distance and visited memories, scan logic and result register.
module wlsp_datapath #(
    parameter int MAX_NODES = wlsp_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = wlsp_pkg::DEF_MAX_EDGES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  wlsp_pkg::t_cmd                 i_cmd,
    input  logic [wlsp_pkg::NODE_IN_W-1:0] i_node_a,
    input  logic [wlsp_pkg::NODE_IN_W-1:0] i_node_b,
    input  logic [wlsp_pkg::LEN_W-1:0]     i_edge_length,
    input  logic [wlsp_pkg::WT_W-1:0]      i_edge_weight,
    input  logic [wlsp_pkg::WT_W-1:0]      i_weight_limit,
    input  logic                           i_stall,
    output wlsp_pkg::t_sts                 o_sts,
    output logic                           o_valid,
    output logic [wlsp_pkg::DIST_W-1:0]    o_distance,
    output logic                           o_reachable,
    output logic                           o_status
);
    import wlsp_pkg::*;

    localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int EDGE_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int LINK_W = $clog2(MAX_EDGES + 1);

    // Memories.
    logic [LINK_W-1:0]    head_mem [MAX_NODES];
    logic [DIST_W-1:0]    dist_mem [MAX_NODES];
    logic                 vis_mem  [MAX_NODES];
    logic [NODE_IN_W-1:0] tgt_mem  [MAX_EDGES];
    logic [LINK_W-1:0]    nxt_mem  [MAX_EDGES];
    logic [LEN_W-1:0]     len_mem  [MAX_EDGES];
    logic [WT_W-1:0]      wt_mem   [MAX_EDGES];

    // Control state.
    logic [NODE_W-1:0] r_ctr;
    logic [LINK_W-1:0] r_count;
    logic              r_out_valid;
    logic              r_scan_v;

    // Item and working registers.
    logic [NODE_IN_W-1:0] r_a, r_b, r_v;
    logic [LEN_W-1:0]     r_len, r_elen;
    logic [WT_W-1:0]      r_wt, r_limit;
    logic [NODE_W-1:0]    r_scan_idx, r_u;
    logic [DIST_W-1:0]    r_best;
    logic                 r_found, r_wt_ok;
    logic [LINK_W-1:0]    r_link;
    logic [DIST_W-1:0]    r_res_dist, r_out_dist;
    logic                 r_res_reach, r_res_status, r_out_reach, r_out_status;

    // Registered memory read data.
    logic [LINK_W-1:0]    r_head_q, r_nxt_q;
    logic [DIST_W-1:0]    r_dist_q;
    logic                 r_vis_q;
    logic [NODE_IN_W-1:0] r_tgt_q;
    logic [LEN_W-1:0]     r_len_q;
    logic [WT_W-1:0]      r_wt_q;

    // Memory ports.
    logic                 head_we, dist_we, vis_we, edge_we;
    logic [NODE_W-1:0]    head_wa, head_ra, dist_wa, vis_wa, node_ra;
    logic [LINK_W-1:0]    head_wd;
    logic [DIST_W-1:0]    dist_wd;
    logic                 vis_wd;
    logic [EDGE_W-1:0]    edge_wa, edge_ra;
    logic [NODE_IN_W-1:0] tgt_wd;

    // Node numbers widened before cutting to the index width.
    logic [NODE_W+NODE_IN_W-1:0] a_ext, b_ext, v_ext, t_ext;
    logic [NODE_W-1:0]           a_idx, b_idx, v_idx, t_idx;
    logic                        v_ok, scan_better;
    logic [LINK_W-1:0]           count_inc, link_dec;
    logic [DIST_W:0]             cand;

    assign a_ext = {{NODE_W{1'b0}}, r_a};
    assign b_ext = {{NODE_W{1'b0}}, r_b};
    assign v_ext = {{NODE_W{1'b0}}, r_v};
    assign t_ext = {{NODE_W{1'b0}}, r_tgt_q};
    assign a_idx = a_ext[NODE_W-1:0];
    assign b_idx = b_ext[NODE_W-1:0];
    assign v_idx = v_ext[NODE_W-1:0];
    assign t_idx = t_ext[NODE_W-1:0];

    assign v_ok        = (32'(r_v) < MAX_NODES);
    assign count_inc   = r_count + 1'b1;
    assign link_dec    = r_link - 1'b1;
    assign cand        = {1'b0, r_best} + (DIST_W+1)'(r_elen);
    assign scan_better = r_scan_v && !r_vis_q && (r_dist_q < r_best);

    assign o_sts.ctr_last = (r_ctr == NODE_W'(MAX_NODES - 1));
    assign o_sts.full     = ((32'(r_count) + 32'd2) > MAX_EDGES);
    assign o_sts.a_ok     = (32'(r_a) < MAX_NODES);
    assign o_sts.b_ok     = (32'(r_b) < MAX_NODES);
    assign o_sts.found    = r_found;
    assign o_sts.link_ok  = (r_link != '0) && (r_link <= r_count);
    assign o_sts.out_busy = r_out_valid && i_stall;

    assign o_valid     = r_out_valid;
    assign o_distance  = r_out_dist;
    assign o_reachable = r_out_reach;
    assign o_status    = r_out_status;

    always_comb begin
        head_we = 1'b0;  head_wa = r_ctr;  head_wd = '0;  head_ra = a_idx;
        dist_we = 1'b0;  dist_wa = r_ctr;  dist_wd = DIST_INF;
        vis_we  = 1'b0;  vis_wa  = r_ctr;  vis_wd  = 1'b0;
        node_ra = r_ctr;
        edge_we = 1'b0;  edge_wa = r_count[EDGE_W-1:0];  tgt_wd = r_b;
        edge_ra = link_dec[EDGE_W-1:0];
        case (i_cmd.op)
            OP_CLEAR_ALL: begin
                head_we = 1'b1;
                dist_we = 1'b1;
                vis_we  = 1'b1;
            end
            OP_CLEAR_RUN: begin
                dist_we = 1'b1;
                vis_we  = 1'b1;
            end
            OP_LINK_A: begin
                edge_we = 1'b1;
                head_we = 1'b1;
                head_wa = a_idx;
                head_wd = count_inc;
            end
            OP_HEAD_RD_B: begin
                head_ra = b_idx;
            end
            OP_LINK_B: begin
                edge_we = 1'b1;
                tgt_wd  = r_a;
                head_we = 1'b1;
                head_wa = b_idx;
                head_wd = count_inc;
            end
            OP_START: begin
                dist_we = o_sts.a_ok;
                dist_wa = a_idx;
                dist_wd = '0;
            end
            OP_SETTLE: begin
                vis_we  = 1'b1;
                vis_wa  = r_u;
                vis_wd  = 1'b1;
                head_ra = r_u;
            end
            OP_EDGE_GOT: begin
                node_ra = t_idx;
            end
            OP_RELAX: begin
                dist_we = v_ok && !r_vis_q && r_wt_ok && (cand < {1'b0, r_dist_q});
                dist_wa = v_idx;
                dist_wd = cand[DIST_W-1:0];
            end
            OP_READ_RD: begin
                node_ra = a_idx;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (head_we) head_mem[head_wa] <= head_wd;
        r_head_q <= head_mem[head_ra];
    end

    always_ff @(posedge i_clk) begin
        if (dist_we) dist_mem[dist_wa] <= dist_wd;
        r_dist_q <= dist_mem[node_ra];
    end

    always_ff @(posedge i_clk) begin
        if (vis_we) vis_mem[vis_wa] <= vis_wd;
        r_vis_q <= vis_mem[node_ra];
    end

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            tgt_mem[edge_wa] <= tgt_wd;
            nxt_mem[edge_wa] <= r_head_q;
            len_mem[edge_wa] <= r_len;
            wt_mem[edge_wa]  <= r_wt;
        end
        r_tgt_q <= tgt_mem[edge_ra];
        r_nxt_q <= nxt_mem[edge_ra];
        r_len_q <= len_mem[edge_ra];
        r_wt_q  <= wt_mem[edge_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_scan_v    <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_CLEAR_ALL, OP_CLEAR_RUN, OP_SCAN: begin
                    r_ctr <= o_sts.ctr_last ? '0 : r_ctr + 1'b1;
                end
                OP_START, OP_SCAN_INIT: begin
                    r_ctr <= '0;
                end
                OP_LINK_A, OP_LINK_B: begin
                    r_count <= count_inc;
                end
                default: begin
                end
            endcase
            r_scan_v <= (i_cmd.op == OP_SCAN);
            if (i_cmd.op == OP_PUSH) r_out_valid <= 1'b1;
            else if (!i_stall)       r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_idx <= r_ctr;
        case (i_cmd.op)
            OP_LOAD: begin
                r_a          <= i_node_a;
                r_b          <= i_node_b;
                r_len        <= i_edge_length;
                r_wt         <= i_edge_weight;
                r_limit      <= i_weight_limit;
                r_res_dist   <= '0;
                r_res_reach  <= 1'b0;
                r_res_status <= 1'b0;
            end
            OP_ADD_CHK: begin
                r_res_status <= o_sts.full;
            end
            OP_START, OP_SCAN_INIT: begin
                r_best  <= DIST_INF;
                r_found <= 1'b0;
            end
            OP_SCAN, OP_SCAN_END: begin
                if (scan_better) begin
                    r_best  <= r_dist_q;
                    r_u     <= r_scan_idx;
                    r_found <= 1'b1;
                end
            end
            OP_LINK_GET: begin
                r_link <= r_head_q;
            end
            OP_EDGE_GOT: begin
                r_link  <= r_nxt_q;
                r_v     <= r_tgt_q;
                r_elen  <= r_len_q;
                r_wt_ok <= (r_wt_q <= r_limit);
            end
            OP_READ_FIN: begin
                r_res_dist  <= o_sts.a_ok ? r_dist_q : DIST_INF;
                r_res_reach <= o_sts.a_ok && (r_dist_q != DIST_INF);
            end
            OP_PUSH: begin
                r_out_dist   <= r_res_dist;
                r_out_reach  <= r_res_reach;
                r_out_status <= r_res_status;
            end
            default: begin
            end
        endcase
    end

endmodule

/* design/weight_limited_shortest_path_top.sv */
// Top level of the weight-limited shortest path block.
// The block keeps an undirected graph as adjacency lists and answers
// single-source shortest path queries that use only edges whose weight is at
// most a given limit. An add item stores an edge and reports status 1 when
// the store has no room for its two entries. A read item returns a node's
// distance from the last run. A run item clears the distance and visited
// memories, then repeats a settle round for every reachable node: a scan over
// the distance memory picks the nearest unvisited node, and each edge of that
// node is read through the single read port of the edge store. After reset
// the block clears its adjacency heads and distances before it takes its
// first item. One item is processed at a time; o_stall is low only while
// the block is idle, and a finished result waits in an output register so the
// next item can be accepted before the previous result is taken.
module weight_limited_shortest_path_top #(
    parameter int MAX_NODES = wlsp_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = wlsp_pkg::DEF_MAX_EDGES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [wlsp_pkg::FUNC_W-1:0]    i_func,
    input  logic [wlsp_pkg::NODE_IN_W-1:0] i_node_a,
    input  logic [wlsp_pkg::NODE_IN_W-1:0] i_node_b,
    input  logic [wlsp_pkg::LEN_W-1:0]     i_edge_length,
    input  logic [wlsp_pkg::WT_W-1:0]      i_edge_weight,
    input  logic [wlsp_pkg::WT_W-1:0]      i_weight_limit,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [wlsp_pkg::DIST_W-1:0]    o_distance,
    output logic                           o_reachable,
    output logic                           o_status
);
    import wlsp_pkg::*;

    // Commands flow from the controller to the datapath, status flows back.
    t_cmd cmd;
    t_sts sts;

    wlsp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    // The datapath latches the item when the controller issues the load command.
    wlsp_datapath #(
        .MAX_NODES (MAX_NODES),
        .MAX_EDGES (MAX_EDGES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_node_a       (i_node_a),
        .i_node_b       (i_node_b),
        .i_edge_length  (i_edge_length),
        .i_edge_weight  (i_edge_weight),
        .i_weight_limit (i_weight_limit),
        .i_stall        (i_stall),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .o_distance     (o_distance),
        .o_reachable    (o_reachable),
        .o_status       (o_status)
    );

endmodule

/* design/wlsp_checker.sv */
// Port-level checker for the shortest path block and its bind statement.
module wlsp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [wlsp_pkg::DIST_W-1:0] o_distance,
    input logic                        o_reachable,
    input logic                        o_status
);
    import wlsp_pkg::*;

    // Items are processed one at a time, so an accepted item blocks the input.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input accepted again right after an item");

    a_reach_finite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_reachable |-> (o_distance != DIST_INF) && !o_status)
        else $error("reachable node with infinite distance");

    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> !o_reachable && (o_distance == '0))
        else $error("store full result carries a distance");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_distance)
            && $stable(o_reachable) && $stable(o_status))
        else $error("stalled result changed");

endmodule

bind weight_limited_shortest_path_top wlsp_checker u_chk (.*);
